@@ rtl/utf8cc_pkg.sv @@
// Shared types and constants for the UTF-8 codepoint collector.
`timescale 1ns / 1ps

package utf8cc_pkg;

    localparam int TABLE_CAPACITY_DEF = 256;
    localparam int CP_W               = 21;
    localparam int BYTE_W             = 8;
    localparam int TOTAL_W            = 9;

    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
    localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7F;
    localparam logic [1:0]        CONT_TAG = 2'b10;

    localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_NUL     = 21'h000000;
    localparam logic [CP_W-1:0] CP_TAB     = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF      = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR      = 21'h00000D;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_EOS   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MALFORMED  = 2'd1,
        ST_UNFINISHED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TU_LOOKUP,
        TU_READ,
        TU_CLEAR
    } unit_cmd_t;

    typedef enum logic [1:0] {
        SU_IDLE,
        SU_SEARCH,
        SU_READ
    } su_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_DRAIN
    } top_state_t;

    typedef struct packed {
        unit_cmd_t         cmd;
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] idx;
    } unit_req_t;

    typedef struct packed {
        logic            done;
        logic            added;
        logic [CP_W-1:0] entry;
    } unit_rsp_t;

    typedef struct packed {
        status_t         status;
        logic            cp_done;
        logic [CP_W-1:0] value;
        logic            unit_go;
        unit_req_t       req;
    } dec_res_t;

endpackage

@@ rtl/utf8cc_decoder.sv @@
// UTF-8 sequence validator and decoder with its pending-byte state.
`timescale 1ns / 1ps

module utf8cc_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic [1:0]                         opcode,
    input  logic [utf8cc_pkg::BYTE_W-1:0]      data_byte,
    input  logic [utf8cc_pkg::BYTE_W-1:0]      entry_index,
    output utf8cc_pkg::dec_res_t               res
);
    import utf8cc_pkg::*;

    logic [BYTE_W-1:0] pend0_reg, pend0_next;
    logic [BYTE_W-1:0] pend1_reg, pend1_next;
    logic [BYTE_W-1:0] pend2_reg, pend2_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [2:0]        len_reg, len_next;
    logic              err_reg, err_next;

    op_t               op;
    logic [2:0]        lead_len;
    logic [CP_W-1:0]   cp_val;
    logic              cp_ok;
    logic              byte_excl;
    logic              cp_excl;
    logic [CP_W-1:0]   byte_cp;

    assign op      = op_t'(opcode);
    assign byte_cp = CP_W'(data_byte);

    always_comb begin
        if (data_byte <= ASCII_HI) begin
            lead_len = 3'd1;
        end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            lead_len = 3'd2;
        end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            lead_len = 3'd3;
        end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    always_comb begin
        case (len_reg)
            3'd2: begin
                cp_val = {10'd0, pend0_reg[4:0], data_byte[5:0]};
                cp_ok  = 1'b1;
            end
            3'd3: begin
                cp_val = {5'd0, pend0_reg[3:0], pend1_reg[5:0], data_byte[5:0]};
                cp_ok  = (cp_val >= CP_MIN3) &&
                         !((cp_val >= CP_SURR_LO) && (cp_val <= CP_SURR_HI));
            end
            3'd4: begin
                cp_val = {pend0_reg[2:0], pend1_reg[5:0], pend2_reg[5:0], data_byte[5:0]};
                cp_ok  = (cp_val >= CP_MIN4) && (cp_val <= CP_MAX);
            end
            default: begin
                cp_val = '0;
                cp_ok  = 1'b0;
            end
        endcase
    end

    assign byte_excl = byte_cp inside {CP_NUL, CP_TAB, CP_LF, CP_CR};
    assign cp_excl   = cp_val inside {CP_NUL, CP_TAB, CP_LF, CP_CR};

    always_comb begin
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        pend2_next    = pend2_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        err_next      = err_reg;
        res.status    = ST_OK;
        res.cp_done   = 1'b0;
        res.value     = '0;
        res.unit_go   = 1'b0;
        res.req.cmd   = TU_LOOKUP;
        res.req.cp    = '0;
        res.req.idx   = entry_index;
        case (op)
            OP_CLEAR: begin
                cnt_next    = '0;
                len_next    = '0;
                err_next    = 1'b0;
                res.unit_go = 1'b1;
                res.req.cmd = TU_CLEAR;
            end
            OP_READ: begin
                res.status  = err_reg ? ST_MALFORMED : ST_OK;
                res.unit_go = 1'b1;
                res.req.cmd = TU_READ;
            end
            OP_EOS: begin
                if (err_reg) begin
                    res.status = ST_MALFORMED;
                end else if (cnt_reg != 3'd0) begin
                    res.status = ST_UNFINISHED;
                    err_next   = 1'b1;
                    cnt_next   = '0;
                    len_next   = '0;
                end
            end
            OP_DATA: begin
                if (err_reg) begin
                    res.status = ST_MALFORMED;
                end else if (cnt_reg == 3'd0) begin
                    if (lead_len == 3'd0) begin
                        err_next   = 1'b1;
                        res.status = ST_MALFORMED;
                    end else if (lead_len == 3'd1) begin
                        res.cp_done = 1'b1;
                        res.value   = byte_cp;
                        res.unit_go = !byte_excl;
                        res.req.cp  = byte_cp;
                    end else begin
                        pend0_next = data_byte;
                        cnt_next   = 3'd1;
                        len_next   = lead_len;
                    end
                end else if (data_byte[7:6] != CONT_TAG) begin
                    err_next   = 1'b1;
                    res.status = ST_MALFORMED;
                    cnt_next   = '0;
                    len_next   = '0;
                end else if ((cnt_reg + 3'd1) < len_reg) begin
                    if (cnt_reg == 3'd1) begin
                        pend1_next = data_byte;
                    end else begin
                        pend2_next = data_byte;
                    end
                    cnt_next = cnt_reg + 3'd1;
                end else begin
                    cnt_next = '0;
                    len_next = '0;
                    if (cp_ok) begin
                        res.cp_done = 1'b1;
                        res.value   = cp_val;
                        res.unit_go = !cp_excl;
                        res.req.cp  = cp_val;
                    end else begin
                        err_next   = 1'b1;
                        res.status = ST_MALFORMED;
                    end
                end
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            len_reg <= '0;
            err_reg <= 1'b0;
        end else if (step) begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            pend2_reg <= pend2_next;
        end
    end

endmodule

@@ rtl/utf8cc_store.sv @@
// Codepoint table with a sequenced linear duplicate search over one compare unit.
`timescale 1ns / 1ps

module utf8cc_store #(
    parameter int TABLE_CAPACITY = utf8cc_pkg::TABLE_CAPACITY_DEF,
    parameter int CNT_W          = $clog2(TABLE_CAPACITY + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   req_go,
    input  utf8cc_pkg::unit_req_t  req,
    output utf8cc_pkg::unit_rsp_t  rsp,
    output logic [CNT_W-1:0]       store_count,
    output logic                   overflow
);
    import utf8cc_pkg::*;

    localparam int IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(TABLE_CAPACITY);
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(TABLE_CAPACITY);

    logic [CP_W-1:0] mem [TABLE_CAPACITY];
    logic [CP_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic            wr_en;

    su_state_t        state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic             in_range_reg, in_range_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             done_reg, done_next;
    logic             added_reg, added_next;
    logic [CP_W-1:0]  entry_reg, entry_next;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] count_ext;

    assign idx_ext   = CMP_W'(req.idx);
    assign count_ext = CMP_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= cp_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cmp_valid_next = 1'b0;
        cp_next        = cp_reg;
        in_range_next  = in_range_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        done_next      = 1'b0;
        added_next     = added_reg;
        entry_next     = entry_reg;
        rd_addr        = ptr_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        case (state_reg)
            SU_IDLE: begin
                if (req_go) begin
                    case (req.cmd)
                        TU_LOOKUP: begin
                            cp_next    = req.cp;
                            ptr_next   = '0;
                            state_next = SU_SEARCH;
                        end
                        TU_READ: begin
                            rd_addr       = idx_ext[IDX_W-1:0];
                            in_range_next = (idx_ext < count_ext) && (idx_ext < CAP_CMP);
                            state_next    = SU_READ;
                        end
                        TU_CLEAR: begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                            done_next  = 1'b1;
                            added_next = 1'b0;
                            entry_next = '0;
                        end
                        default: begin
                            state_next = SU_IDLE;
                        end
                    endcase
                end
            end
            SU_SEARCH: begin
                if (cmp_valid_reg && (rd_data_reg == cp_reg)) begin
                    done_next  = 1'b1;
                    added_next = 1'b0;
                    entry_next = '0;
                    state_next = SU_IDLE;
                end else if (ptr_reg < count_reg) begin
                    rd_addr        = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end else begin
                    if (count_reg < CAP_CNT) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        added_next = 1'b1;
                    end else begin
                        ovf_next   = 1'b1;
                        added_next = 1'b0;
                    end
                    done_next  = 1'b1;
                    entry_next = '0;
                    state_next = SU_IDLE;
                end
            end
            SU_READ: begin
                done_next  = 1'b1;
                added_next = 1'b0;
                entry_next = in_range_reg ? rd_data_reg : '0;
                state_next = SU_IDLE;
            end
            default: begin
                state_next = SU_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SU_IDLE;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg       <= cp_next;
        in_range_reg <= in_range_next;
        added_reg    <= added_next;
        entry_reg    <= entry_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.added   = added_reg;
    assign rsp.entry   = entry_reg;
    assign store_count = count_reg;
    assign overflow    = ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("store count above capacity");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SU_SEARCH) |-> (ptr_reg <= count_reg))
        else $error("search pointer beyond stored entries");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("response held for more than one cycle");

    a_done_needs_req: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == SU_IDLE) && !req_go) |=> !done_reg)
        else $error("response without a request");

endmodule

@@ rtl/utf8_stream_codepoint_collector_core.sv @@
// Top level of the UTF-8 stream codepoint collector.
// Usage:
//   Input channel (s_valid/s_ready) carries one request: a data byte, end of
//   stream, clear all, or a read of one table entry. Output channel
//   (m_valid/m_ready) returns exactly one result per request, in order.
//   Bytes are validated and decoded; each new codepoint other than NUL, TAB,
//   LF or CR is appended to a table of unique codepoints after a linear
//   duplicate search, while the table has room; else the overflow flag is set.
// Timing:
//   s_ready is high only while no request is in progress, one request at a
//   time. A lookup runs a search loop that reads one stored entry per cycle
//   through the single table read port and comparator, and stops at a match
//   or after the last stored entry; a clear or a read uses the table unit
//   without a search. s_ready rises with m_valid.
// Reset (aresetn, synchronous, active low) empties the table, clears the
//   error and overflow flags and drops any partial sequence; no sweep runs.
// A stalled receiver holds the result in the output register; the next
//   request is still accepted and processed, then waits for the register.
`timescale 1ns / 1ps

module utf8_stream_codepoint_collector_core #(
    parameter int TABLE_CAPACITY = utf8cc_pkg::TABLE_CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_opcode,
    input  logic [utf8cc_pkg::BYTE_W-1:0]        s_data_byte,
    input  logic [utf8cc_pkg::BYTE_W-1:0]        s_entry_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic                                 m_codepoint_done,
    output logic [utf8cc_pkg::CP_W-1:0]          m_decoded_value,
    output logic                                 m_newly_added,
    output logic [utf8cc_pkg::TOTAL_W-1:0]       m_entry_total,
    output logic                                 m_overflowed,
    output logic [utf8cc_pkg::CP_W-1:0]          m_entry_value
);
    import utf8cc_pkg::*;

    localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);

    top_state_t       state_reg, state_next;
    dec_res_t         dec_res;
    unit_rsp_t        unit_rsp;
    logic [CNT_W-1:0] store_count;
    logic             store_ovf;
    logic             dec_step;
    logic             unit_go;

    status_t          status_reg, status_next;
    logic             done_reg, done_next;
    logic [CP_W-1:0]  value_reg, value_next;
    logic             added_reg, added_next;
    logic [CP_W-1:0]  entry_reg, entry_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic               m_done_reg, m_done_next;
    logic [CP_W-1:0]    m_value_reg, m_value_next;
    logic               m_added_reg, m_added_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;
    logic               m_ovf_reg, m_ovf_next;
    logic [CP_W-1:0]    m_entry_reg, m_entry_next;

    assign s_ready  = (state_reg == T_IDLE);
    assign dec_step = s_valid && s_ready;
    assign unit_go  = dec_step && dec_res.unit_go;

    utf8cc_decoder u_decoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (dec_step),
        .opcode      (s_opcode),
        .data_byte   (s_data_byte),
        .entry_index (s_entry_index),
        .res         (dec_res)
    );

    utf8cc_store #(
        .TABLE_CAPACITY (TABLE_CAPACITY),
        .CNT_W          (CNT_W)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_go      (unit_go),
        .req         (dec_res.req),
        .rsp         (unit_rsp),
        .store_count (store_count),
        .overflow    (store_ovf)
    );

    always_comb begin
        state_next    = state_reg;
        status_next   = status_reg;
        done_next     = done_reg;
        value_next    = value_reg;
        added_next    = added_reg;
        entry_next    = entry_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_done_next   = m_done_reg;
        m_value_next  = m_value_reg;
        m_added_next  = m_added_reg;
        m_total_next  = m_total_reg;
        m_ovf_next    = m_ovf_reg;
        m_entry_next  = m_entry_reg;
        case (state_reg)
            T_IDLE: begin
                if (dec_step) begin
                    status_next = dec_res.status;
                    done_next   = dec_res.cp_done;
                    value_next  = dec_res.value;
                    added_next  = 1'b0;
                    entry_next  = '0;
                    state_next  = dec_res.unit_go ? T_BUSY : T_DRAIN;
                end
            end
            T_BUSY: begin
                if (unit_rsp.done) begin
                    added_next = unit_rsp.added;
                    entry_next = unit_rsp.entry;
                    state_next = T_DRAIN;
                end
            end
            T_DRAIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_done_next   = done_reg;
                    m_value_next  = value_reg;
                    m_added_next  = added_reg;
                    m_total_next  = TOTAL_W'(store_count);
                    m_ovf_next    = store_ovf;
                    m_entry_next  = entry_reg;
                    state_next    = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        done_reg     <= done_next;
        value_reg    <= value_next;
        added_reg    <= added_next;
        entry_reg    <= entry_next;
        m_status_reg <= m_status_next;
        m_done_reg   <= m_done_next;
        m_value_reg  <= m_value_next;
        m_added_reg  <= m_added_next;
        m_total_reg  <= m_total_next;
        m_ovf_reg    <= m_ovf_next;
        m_entry_reg  <= m_entry_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_codepoint_done = m_done_reg;
    assign m_decoded_value  = m_value_reg;
    assign m_newly_added    = m_added_reg;
    assign m_entry_total    = m_total_reg;
    assign m_overflowed     = m_ovf_reg;
    assign m_entry_value    = m_entry_reg;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the UTF-8 stream codepoint collector core.
`timescale 1ns / 1ps

module testbench;
    import utf8cc_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        status_t            status;
        logic               cp_done;
        logic [CP_W-1:0]    value;
        logic               added;
        logic [TOTAL_W-1:0] total;
        logic               full;
        logic [CP_W-1:0]    entry;
    } collect_out_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_opcode;
    logic [BYTE_W-1:0]   s_data_byte;
    logic [BYTE_W-1:0]   s_entry_index;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_status;
    logic                m_codepoint_done;
    logic [CP_W-1:0]     m_decoded_value;
    logic                m_newly_added;
    logic [TOTAL_W-1:0]  m_entry_total;
    logic                m_overflowed;
    logic [CP_W-1:0]     m_entry_value;

    // shadow state of the collector
    logic [BYTE_W-1:0]   held_bytes [3];
    int                  held_count;
    int                  seq_len;
    logic [CP_W-1:0]     unique_cps [TABLE_CAPACITY_DEF];
    int                  unique_count;
    bit                  table_overflow;
    bit                  stream_error;

    collect_out_t        outcomes_due [$];
    bit                  no_gaps;
    int                  live_items;
    int                  error_count;
    int                  result_count;
    int                  stall_left;
    int                  cycle_count;

    utf8_stream_codepoint_collector_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_data_byte      (s_data_byte),
        .s_entry_index    (s_entry_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_codepoint_done (m_codepoint_done),
        .m_decoded_value  (m_decoded_value),
        .m_newly_added    (m_newly_added),
        .m_entry_total    (m_entry_total),
        .m_overflowed     (m_overflowed),
        .m_entry_value    (m_entry_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void clear_collector();
        held_count     = 0;
        seq_len        = 0;
        unique_count   = 0;
        table_overflow = 1'b0;
        stream_error   = 1'b0;
    endfunction

    function automatic bit store_if_new(logic [CP_W-1:0] cp);
        if (cp == CP_NUL || cp == CP_CR || cp == CP_LF || cp == CP_TAB) return 1'b0;
        for (int i = 0; i < unique_count; i++) begin
            if (unique_cps[i] == cp) return 1'b0;
        end
        if (unique_count >= TABLE_CAPACITY_DEF) begin
            table_overflow = 1'b1;
            return 1'b0;
        end
        unique_cps[unique_count] = cp;
        unique_count++;
        return 1'b1;
    endfunction

    function automatic collect_out_t decode_request(op_t op, logic [BYTE_W-1:0] b,
                                                    logic [BYTE_W-1:0] idx);
        collect_out_t    r;
        logic [CP_W-1:0] cp;
        bit              ok;
        int              len;
        r  = '0;
        cp = '0;
        ok = 1'b0;
        case (op)
            OP_CLEAR: begin
                clear_collector();
            end
            OP_READ: begin
                if (idx < unique_count) r.entry = unique_cps[idx];
                r.status = stream_error ? ST_MALFORMED : ST_OK;
            end
            OP_EOS: begin
                if (stream_error) begin
                    r.status = ST_MALFORMED;
                end else if (held_count != 0) begin
                    r.status     = ST_UNFINISHED;
                    stream_error = 1'b1;
                    held_count   = 0;
                    seq_len      = 0;
                end
            end
            default: begin
                if (stream_error) begin
                    r.status = ST_MALFORMED;
                end else if (held_count == 0) begin
                    if (b <= ASCII_HI) len = 1;
                    else if (b >= LEAD2_LO && b <= LEAD2_HI) len = 2;
                    else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3;
                    else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 4;
                    else len = 0;
                    if (len == 0) begin
                        stream_error = 1'b1;
                        r.status     = ST_MALFORMED;
                    end else if (len == 1) begin
                        r.cp_done = 1'b1;
                        r.value   = CP_W'(b);
                        r.added   = store_if_new(CP_W'(b));
                    end else begin
                        held_bytes[0] = b;
                        held_count    = 1;
                        seq_len       = len;
                    end
                end else if (b[7:6] != CONT_TAG) begin
                    stream_error = 1'b1;
                    r.status     = ST_MALFORMED;
                    held_count   = 0;
                    seq_len      = 0;
                end else if (held_count + 1 < seq_len) begin
                    held_bytes[held_count] = b;
                    held_count++;
                end else begin
                    case (seq_len)
                        2: begin
                            cp = CP_W'({held_bytes[0][4:0], b[5:0]});
                            ok = 1'b1;
                        end
                        3: begin
                            cp = CP_W'({held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]});
                            ok = cp >= CP_MIN3 && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
                        end
                        default: begin
                            cp = {held_bytes[0][2:0], held_bytes[1][5:0],
                                  held_bytes[2][5:0], b[5:0]};
                            ok = cp >= CP_MIN4 && cp <= CP_MAX;
                        end
                    endcase
                    held_count = 0;
                    seq_len    = 0;
                    if (ok) begin
                        r.cp_done = 1'b1;
                        r.value   = cp;
                        r.added   = store_if_new(cp);
                    end else begin
                        stream_error = 1'b1;
                        r.status     = ST_MALFORMED;
                    end
                end
            end
        endcase
        r.total = TOTAL_W'(unique_count);
        r.full  = table_overflow;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch on result %0d at %0t: %s", result_count, $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        collect_out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            result_count++;
            if (outcomes_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = outcomes_due.pop_front();
                check_field("status", 32'(m_status), 32'(want.status));
                check_field("codepoint_done", 32'(m_codepoint_done), 32'(want.cp_done));
                check_field("decoded_value", 32'(m_decoded_value), 32'(want.value));
                check_field("newly_added", 32'(m_newly_added), 32'(want.added));
                check_field("entry_total", 32'(m_entry_total), 32'(want.total));
                check_field("overflowed", 32'(m_overflowed), 32'(want.full));
                check_field("entry_value", 32'(m_entry_value), 32'(want.entry));
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 4);
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_request(op_t op, logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] index);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_data_byte   <= data;
        s_entry_index <= index;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        if (!(op == OP_DATA && stream_error)) live_items++;
        outcomes_due.push_back(decode_request(op, data, index));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        send_request(OP_DATA, b, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_codepoint(logic [CP_W-1:0] cp);
        if (cp < 21'h80) begin
            send_byte(cp[7:0]);
        end else if (cp < CP_MIN3) begin
            send_byte({3'b110, cp[10:6]});
            send_byte({CONT_TAG, cp[5:0]});
        end else if (cp < CP_MIN4) begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({CONT_TAG, cp[11:6]});
            send_byte({CONT_TAG, cp[5:0]});
        end else begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({CONT_TAG, cp[17:12]});
            send_byte({CONT_TAG, cp[11:6]});
            send_byte({CONT_TAG, cp[5:0]});
        end
    endtask

    task automatic send_control(op_t op);
        send_request(op, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drain(int hold);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (hold) @(posedge aclk);
    endtask

    function automatic logic [CP_W-1:0] pick_codepoint();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 9))
            0, 1: begin
                if (unique_count > 0) cp = unique_cps[$urandom_range(0, unique_count - 1)];
                else cp = 21'h41;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: cp = CP_NUL;
                    1: cp = CP_TAB;
                    2: cp = CP_LF;
                    default: cp = CP_CR;
                endcase
            end
            3, 4: cp = CP_W'($urandom_range(0, 'h7F));
            5: cp = CP_W'($urandom_range('h80, 'h7FF));
            6, 7: begin
                cp = CP_W'($urandom_range('h800, 'hFFFF));
                if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h002000;
            end
            default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic send_broken();
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] bad;
        case ($urandom_range(0, 6))
            0: begin
                if ($urandom_range(0, 1)) send_byte(BYTE_W'($urandom_range('h80, 'hC1)));
                else send_byte(BYTE_W'($urandom_range('hF5, 'hFF)));
            end
            1: begin
                send_byte(8'hE0);
                send_byte(BYTE_W'($urandom_range('h80, 'h9F)));
                send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
            end
            2: begin
                send_byte(8'hED);
                send_byte(BYTE_W'($urandom_range('hA0, 'hBF)));
                send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
            end
            3: begin
                send_byte(8'hF0);
                send_byte(BYTE_W'($urandom_range('h80, 'h8F)));
                send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
                send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
            end
            4: begin
                send_byte(8'hF4);
                send_byte(BYTE_W'($urandom_range('h90, 'hBF)));
                send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
                send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
            end
            5: begin
                lead = BYTE_W'($urandom_range('hC2, 'hF4));
                send_byte(lead);
                if (lead >= LEAD3_LO && $urandom_range(0, 1))
                    send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
                bad = BYTE_W'($urandom_range(0, 255));
                if (bad[7:6] == CONT_TAG) bad[6] = 1'b1;
                send_byte(bad);
            end
            default: begin
                lead = BYTE_W'($urandom_range('hC2, 'hF4));
                send_byte(lead);
                if (lead >= LEAD3_LO && $urandom_range(0, 1))
                    send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
                send_control(OP_EOS);
            end
        endcase
    endtask

    task automatic test_idle_after_reset();
        send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), 8'd0);
        send_control(OP_EOS);
        send_control(OP_READ);
    endtask

    task automatic test_codepoint_extremes();
        send_codepoint(CP_NUL);
        send_codepoint(21'h7F);
        send_codepoint(21'h80);
        send_codepoint(CP_MAX);
        send_codepoint(21'h7F);
        send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), 8'd1);
        send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), 8'd255);
    endtask

    task automatic test_malformed_lead();
        send_byte(8'hC1);
        send_byte(8'h41);
        send_control(OP_EOS);
        send_control(OP_CLEAR);
    endtask

    task automatic test_overlong_rejected();
        send_byte(8'hE0);
        send_byte(8'h9F);
        send_byte(8'hBF);
        send_control(OP_CLEAR);
    endtask

    task automatic test_unfinished_stream();
        send_byte(8'hF0);
        send_byte(8'h90);
        send_control(OP_EOS);
        send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), 8'd0);
        send_control(OP_CLEAR);
    endtask

    task automatic test_table_overflow();
        send_control(OP_CLEAR);
        for (int i = 0; i < TABLE_CAPACITY_DEF; i++) begin
            send_codepoint(CP_W'(32'h80 + (i << 2) + $urandom_range(0, 3)));
        end
        send_codepoint(21'h41);
        send_codepoint(unique_cps[$urandom_range(0, TABLE_CAPACITY_DEF - 1)]);
        send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), 8'd255);
        send_request(OP_READ, BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)));
        send_control(OP_CLEAR);
    endtask

    task automatic test_drain_pause();
        repeat (4) send_codepoint(pick_codepoint());
        wait_drain($urandom_range(1, 30));
        repeat (4) send_codepoint(pick_codepoint());
    endtask

    task automatic test_random_stream();
        int start;
        int next_chunk;
        int next_pause;
        int pick;
        start      = live_items;
        next_chunk = 0;
        next_pause = 300;
        while (live_items - start < RANDOM_ITEMS) begin
            if (live_items - start >= next_chunk) begin
                next_chunk += 100;
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (live_items - start >= next_pause) begin
                next_pause += 300;
                wait_drain($urandom_range(0, 10));
            end
            pick = $urandom_range(0, 99);
            if (stream_error && pick < 60) begin
                send_control(OP_CLEAR);
            end else if (pick < 55) begin
                send_codepoint(pick_codepoint());
            end else if (pick < 65) begin
                if (unique_count > 0 && $urandom_range(0, 1))
                    send_request(OP_READ, BYTE_W'($urandom_range(0, 255)),
                                 BYTE_W'($urandom_range(0, unique_count - 1)));
                else
                    send_control(OP_READ);
            end else if (pick < 73) begin
                send_broken();
            end else if (pick < 78) begin
                send_control(OP_EOS);
            end else if (pick < 81) begin
                send_control(OP_CLEAR);
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_opcode      <= OP_DATA;
        s_data_byte   <= '0;
        s_entry_index <= '0;
        no_gaps       = 1'b0;
        live_items    = 0;
        error_count   = 0;
        result_count  = 0;
        stall_left    = 0;
        clear_collector();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_after_reset();
        test_codepoint_extremes();
        test_malformed_lead();
        test_overlong_rejected();
        test_unfinished_stream();
        test_table_overflow();
        test_drain_pause();
        test_random_stream();

        wait_drain(300);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/utf8cc_pkg.sv
rtl/utf8cc_decoder.sv
rtl/utf8cc_store.sv
rtl/utf8_stream_codepoint_collector_core.sv
bench/testbench.sv
